@@ rtl/core/cpra_pkg.sv @@
package cpra_pkg;

    localparam int NUM_PAGES_DEF = 4096;
    localparam int CNT_W         = 13;
    localparam int IDX_W         = 12;
    localparam int TYPE_W        = 12;
    localparam int FLAG_W        = 15;
    localparam logic [CNT_W-1:0] PAGES_RST = 13'd4096;

    // flag entry bits
    localparam int FB_ALLOC = 12;
    localparam int FB_FIRST = 13;
    localparam int FB_NEXT  = 14;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_NOSPACE = 3'd1,
        ST_BOUNDS  = 3'd2,
        ST_NOTHEAD = 3'd3,
        ST_ZERO    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_ALLOC  = 2'd0,
        OP_ZERO   = 2'd1,
        OP_FREE   = 2'd2,
        OP_BOUNDS = 2'd3
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CNT_W-1:0]  count;
        logic [TYPE_W-1:0] ptype;
        logic [IDX_W-1:0]  idx;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [IDX_W-1:0]  start;
        logic [CNT_W-1:0]  done;
        logic [CNT_W-1:0]  total;
    } t_result;

    function automatic int pos_width(input int n);
        int w;
        w = $clog2(n + 1);
        return (w > CNT_W) ? w : CNT_W;
    endfunction

endpackage

@@ rtl/core/cpra_fifo.sv @@
module cpra_fifo #(
    parameter type T = logic
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    T           r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push_ok;
    logic       pop_ok;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push_ok) begin
                r_wp <= ~r_wp;
            end
            if (pop_ok) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push_ok} - {1'b0, pop_ok};
        end
    end

endmodule

@@ rtl/core/cpra_front.sv @@
module cpra_front #(
    parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF,
    parameter int PW        = cpra_pkg::pos_width(NUM_PAGES)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic                           i_cmd,
    input  logic [cpra_pkg::CNT_W-1:0]     i_run_length,
    input  logic [cpra_pkg::TYPE_W-1:0]    i_page_type,
    input  logic [cpra_pkg::IDX_W-1:0]     i_page_index,
    input  logic [PW-1:0]                  i_len,
    input  logic                           i_clearing,
    input  logic                           i_cmd_pop,
    output cpra_pkg::t_cmd                 o_cmd,
    output logic                           o_cmd_valid
);

    cpra_pkg::t_cmd cls;
    logic           q_full;
    logic           q_empty;

    always_comb begin
        cls.count = i_run_length;
        cls.ptype = i_page_type;
        cls.idx   = i_page_index;
        if (i_cmd) begin
            cls.op = (PW'(i_page_index) < i_len) ? cpra_pkg::OP_FREE : cpra_pkg::OP_BOUNDS;
        end else begin
            cls.op = (i_run_length == '0) ? cpra_pkg::OP_ZERO : cpra_pkg::OP_ALLOC;
        end
    end

    assign o_full      = q_full || i_clearing;
    assign o_cmd_valid = !q_empty;

    cpra_fifo #(.T(cpra_pkg::t_cmd)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push && !o_full),
        .i_data  (cls),
        .o_full  (q_full),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd),
        .o_empty (q_empty)
    );

endmodule

@@ rtl/core/cpra_engine.sv @@
module cpra_engine #(
    parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF,
    parameter int PW        = cpra_pkg::pos_width(NUM_PAGES)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [PW-1:0]     i_len,
    input  logic              i_cmd_valid,
    input  cpra_pkg::t_cmd    i_cmd,
    output logic              o_cmd_pop,
    input  logic              i_out_full,
    output logic              o_res_push,
    output cpra_pkg::t_result o_res,
    output logic              o_clearing
);

    localparam int IW = $clog2(NUM_PAGES);
    localparam int FW = cpra_pkg::FLAG_W;

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_SCAN, S_MARK, S_FRD, S_FEV, S_DONE
    } t_state;

    t_state             r_state;
    logic [FW-1:0]      r_mem [NUM_PAGES];
    logic [FW-1:0]      r_rdata;
    logic [PW-1:0]      r_addr;
    logic [PW-1:0]      r_hi;
    logic               r_pend;
    logic               r_pass2;
    logic [PW-1:0]      r_ppos;
    logic [PW-1:0]      r_run;
    logic [PW-1:0]      r_first;
    logic [PW-1:0]      r_pos;
    logic [PW-1:0]      r_cnt;
    logic [PW-1:0]      r_hint;
    logic [PW-1:0]      r_total;
    logic [PW-1:0]      r_done;
    cpra_pkg::t_cmd     r_cmd;
    cpra_pkg::t_status  r_status;
    logic [cpra_pkg::IDX_W-1:0] r_start;

    logic               mem_we;
    logic               mem_re;
    logic [PW-1:0]      mem_wa;
    logic [FW-1:0]      mem_wd;
    logic [PW-1:0]      cnt_ext;
    logic               pg_free;
    logic               hit;
    logic [PW-1:0]      hit_pos;
    logic               head_bad;
    logic               walk_stop;
    logic [PW-1:0]      walk_done;
    logic [PW-1:0]      mark_end;

    assign cnt_ext   = PW'(r_cmd.count);
    assign pg_free   = (r_rdata[FW-1:cpra_pkg::FB_ALLOC] == '0);
    assign hit       = r_pend && pg_free && ((r_run + 1'b1) == cnt_ext);
    assign hit_pos   = (r_run == '0) ? r_ppos : r_first;
    assign head_bad  = (r_cnt == '0) && !r_rdata[cpra_pkg::FB_FIRST];
    assign walk_stop = !r_rdata[cpra_pkg::FB_ALLOC];
    assign walk_done = r_cnt + 1'b1;
    assign mark_end  = r_pos + cnt_ext;

    assign o_clearing = (r_state == S_CLEAR);
    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid && !i_out_full;
    assign o_res_push = (r_state == S_DONE);

    always_comb begin
        o_res.status = r_status;
        o_res.start  = r_start;
        o_res.done   = r_done[cpra_pkg::CNT_W-1:0];
        o_res.total  = r_total[cpra_pkg::CNT_W-1:0];
    end

    always_comb begin
        mem_we = 1'b0;
        mem_re = 1'b0;
        mem_wa = r_addr;
        mem_wd = '0;
        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
            end
            S_SCAN: begin
                mem_re = !hit && (r_addr < r_hi);
            end
            S_MARK: begin
                mem_we = 1'b1;
                mem_wa = r_pos + r_cnt;
                mem_wd = {((r_cnt + 1'b1) < cnt_ext), (r_cnt == '0), 1'b1, r_cmd.ptype};
            end
            S_FEV: begin
                mem_we = !head_bad && !walk_stop;
                mem_wa = r_pos;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa[IW-1:0]] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[r_addr[IW-1:0]];
        end else if (r_state == S_FRD) begin
            r_rdata <= r_mem[r_pos[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_pend  <= 1'b0;
            r_hint  <= '0;
            r_total <= '0;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    if (r_addr == PW'(NUM_PAGES - 1)) begin
                        r_addr  <= '0;
                        r_state <= S_IDLE;
                    end else begin
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (o_cmd_pop) begin
                        r_cmd   <= i_cmd;
                        r_start <= '0;
                        r_done  <= '0;
                        r_run   <= '0;
                        r_pend  <= 1'b0;
                        unique case (i_cmd.op)
                            cpra_pkg::OP_ZERO: begin
                                r_status <= cpra_pkg::ST_ZERO;
                                r_state  <= S_DONE;
                            end
                            cpra_pkg::OP_BOUNDS: begin
                                r_status <= cpra_pkg::ST_BOUNDS;
                                r_start  <= i_cmd.idx;
                                r_state  <= S_DONE;
                            end
                            cpra_pkg::OP_FREE: begin
                                r_pos   <= PW'(i_cmd.idx);
                                r_cnt   <= '0;
                                r_start <= i_cmd.idx;
                                r_state <= S_FRD;
                            end
                            cpra_pkg::OP_ALLOC: begin
                                if (r_hint < i_len) begin
                                    r_addr  <= r_hint;
                                    r_hi    <= i_len;
                                    r_pass2 <= 1'b0;
                                    r_state <= S_SCAN;
                                end else if (r_hint != '0) begin
                                    r_addr  <= '0;
                                    r_hi    <= i_len;
                                    r_pass2 <= 1'b1;
                                    r_state <= S_SCAN;
                                end else begin
                                    r_status <= cpra_pkg::ST_NOSPACE;
                                    r_hint   <= '0;
                                    r_state  <= S_DONE;
                                end
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    if (hit) begin
                        r_pend  <= 1'b0;
                        r_pos   <= hit_pos;
                        r_start <= hit_pos[cpra_pkg::IDX_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_MARK;
                    end else begin
                        if (r_pend) begin
                            if (pg_free) begin
                                if (r_run == '0) begin
                                    r_first <= r_ppos;
                                end
                                r_run <= r_run + 1'b1;
                            end else begin
                                r_run <= '0;
                            end
                        end
                        if (r_addr < r_hi) begin
                            r_pend <= 1'b1;
                            r_ppos <= r_addr;
                            r_addr <= r_addr + 1'b1;
                        end else begin
                            r_pend <= 1'b0;
                            if (!r_pend) begin
                                if (!r_pass2 && (r_hint != '0)) begin
                                    r_pass2 <= 1'b1;
                                    r_addr  <= '0;
                                    r_hi    <= (r_hint < i_len) ? r_hint : i_len;
                                    r_run   <= '0;
                                end else begin
                                    r_status <= cpra_pkg::ST_NOSPACE;
                                    r_hint   <= '0;
                                    r_state  <= S_DONE;
                                end
                            end
                        end
                    end
                end
                S_MARK: begin
                    if ((r_cnt + 1'b1) == cnt_ext) begin
                        r_status <= cpra_pkg::ST_OK;
                        r_done   <= cnt_ext;
                        r_total  <= r_total + cnt_ext;
                        r_hint   <= (mark_end >= i_len) ? '0 : mark_end;
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_FRD: begin
                    r_state <= S_FEV;
                end
                S_FEV: begin
                    if (head_bad) begin
                        r_status <= cpra_pkg::ST_NOTHEAD;
                        r_state  <= S_DONE;
                    end else if (walk_stop) begin
                        r_status <= cpra_pkg::ST_OK;
                        r_done   <= r_cnt;
                        r_total  <= r_total - ((r_cnt <= r_total) ? r_cnt : r_total);
                        r_hint   <= PW'(r_cmd.idx);
                        r_state  <= S_DONE;
                    end else if (!r_rdata[cpra_pkg::FB_NEXT] || ((r_pos + 1'b1) >= i_len)) begin
                        r_status <= cpra_pkg::ST_OK;
                        r_done   <= walk_done;
                        r_total  <= r_total - ((walk_done <= r_total) ? walk_done : r_total);
                        r_hint   <= PW'(r_cmd.idx);
                        r_state  <= S_DONE;
                    end else begin
                        r_cnt   <= walk_done;
                        r_pos   <= r_pos + 1'b1;
                        r_state <= S_FRD;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ rtl/core/contiguous_page_run_allocator.sv @@
// allocate: scans flag entries from the search hint up to the managed length, wraps to 0
// if needed, then marks run_length entries, one flag entry per cycle on the single-port flag memory
// free: each page walked is read (S_FRD), then checked and cleared (S_FEV)
// one command runs at a time; up to two commands and two results are queued
// reset clears control state, then a pass over every entry clears the flag table
// with full held high; configuration writes are taken throughout
module contiguous_page_run_allocator #(
    parameter int NUM_PAGES = cpra_pkg::NUM_PAGES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        i_cmd,
    input  logic [cpra_pkg::CNT_W-1:0]  i_run_length,
    input  logic [cpra_pkg::TYPE_W-1:0] i_page_type,
    input  logic [cpra_pkg::IDX_W-1:0]  i_page_index,
    output logic                        empty,
    input  logic                        pop,
    output logic [2:0]                  o_status,
    output logic [cpra_pkg::IDX_W-1:0]  o_start_index,
    output logic [cpra_pkg::CNT_W-1:0]  o_pages_done,
    output logic [cpra_pkg::CNT_W-1:0]  o_allocated_total,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [cpra_pkg::CNT_W-1:0]  i_cfg_data
);

    localparam int PW = cpra_pkg::pos_width(NUM_PAGES);

    logic [cpra_pkg::CNT_W-1:0] r_pages;
    logic [PW-1:0]              pages_ext;
    logic [PW-1:0]              len;
    cpra_pkg::t_cmd             cmd;
    logic                       cmd_valid;
    logic                       cmd_pop;
    logic                       clearing;
    logic                       out_full;
    logic                       res_push;
    cpra_pkg::t_result          res;
    cpra_pkg::t_result          res_head;

    assign o_cfg_ready = 1'b1;
    assign pages_ext   = PW'(r_pages);
    assign len         = (pages_ext < PW'(NUM_PAGES)) ? pages_ext : PW'(NUM_PAGES);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pages <= cpra_pkg::PAGES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pages <= i_cfg_data;
        end
    end

    cpra_front #(.NUM_PAGES(NUM_PAGES), .PW(PW)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_cmd        (i_cmd),
        .i_run_length (i_run_length),
        .i_page_type  (i_page_type),
        .i_page_index (i_page_index),
        .i_len        (len),
        .i_clearing   (clearing),
        .i_cmd_pop    (cmd_pop),
        .o_cmd        (cmd),
        .o_cmd_valid  (cmd_valid)
    );

    cpra_engine #(.NUM_PAGES(NUM_PAGES), .PW(PW)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_len       (len),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_pop   (cmd_pop),
        .i_out_full  (out_full),
        .o_res_push  (res_push),
        .o_res       (res),
        .o_clearing  (clearing)
    );

    cpra_fifo #(.T(cpra_pkg::t_result)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (res_head),
        .o_empty (empty)
    );

    assign o_status          = res_head.status;
    assign o_start_index     = res_head.start;
    assign o_pages_done      = res_head.done;
    assign o_allocated_total = res_head.total;

endmodule

@@ rtl/core/cpra_checker.sv @@
module cpra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_status,
    input logic [11:0] o_start_index,
    input logic [12:0] o_pages_done
);

    a_clear_blocks: assert property (@(posedge i_clk) !i_rst_n |=> full)
        else $error("input not blocked after reset");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_status <= 3'd4))
        else $error("bad status code");

    a_err_no_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status != 3'd0)) |-> (o_pages_done == 13'd0))
        else $error("pages reported on error");

    a_ok_has_pages: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_status == 3'd0)) |-> (o_pages_done != 13'd0))
        else $error("ok with no pages");

    a_word_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_status) && $stable(o_start_index)))
        else $error("waiting word changed");

endmodule

bind contiguous_page_run_allocator cpra_checker u_cpra_checker (.*);

@@ verif/tb_contiguous_page_run_allocator.sv @@
module tb_contiguous_page_run_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit CMD_ALLOC = 1'b0;
    localparam bit CMD_FREE  = 1'b1;
    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        bit                                 is_cfg;
        bit                                 typed;
        bit                                 cmd;
        logic [cpra_pkg::CNT_W-1:0]         cnt;
        logic [cpra_pkg::TYPE_W-1:0]        ptype;
        logic [cpra_pkg::IDX_W-1:0]         idx;
        cpra_pkg::t_result                  want;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           push = 1'b0;
    logic                           full;
    logic                           i_cmd = 1'b0;
    logic [cpra_pkg::CNT_W-1:0]     i_run_length = '0;
    logic [cpra_pkg::TYPE_W-1:0]    i_page_type = '0;
    logic [cpra_pkg::IDX_W-1:0]     i_page_index = '0;
    logic                           empty;
    logic                           pop = 1'b0;
    logic [2:0]                     o_status;
    logic [cpra_pkg::IDX_W-1:0]     o_start_index;
    logic [cpra_pkg::CNT_W-1:0]     o_pages_done;
    logic [cpra_pkg::CNT_W-1:0]     o_allocated_total;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [cpra_pkg::CNT_W-1:0]     i_cfg_data = '0;

    // predictor state
    logic [cpra_pkg::FLAG_W-1:0]    pg_flags [cpra_pkg::NUM_PAGES_DEF];
    int                             search_hint;
    int                             alloc_total;
    int                             pages_cfg;

    cpra_pkg::t_result              result_q [$];
    int                             head_q [$];
    t_row                           dir_rows [$];
    int                             err_cnt = 0;
    int                             cycles = 0;
    bit                             no_idle = 1'b0;

    contiguous_page_run_allocator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_cmd             (i_cmd),
        .i_run_length      (i_run_length),
        .i_page_type       (i_page_type),
        .i_page_index      (i_page_index),
        .empty             (empty),
        .pop               (pop),
        .o_status          (o_status),
        .o_start_index     (o_start_index),
        .o_pages_done      (o_pages_done),
        .o_allocated_total (o_allocated_total),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_contiguous_page_run_allocator failed");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int managed_len();
        return (pages_cfg < cpra_pkg::NUM_PAGES_DEF) ? pages_cfg : cpra_pkg::NUM_PAGES_DEF;
    endfunction

    function automatic bit find_free_run(input int lo, input int hi, input int cnt,
                                         output int first);
        int run;
        int i;
        run = 0;
        first = 0;
        for (i = lo; i < hi; i++) begin
            if (!pg_flags[i][cpra_pkg::FB_ALLOC] && !pg_flags[i][cpra_pkg::FB_FIRST]
                && !pg_flags[i][cpra_pkg::FB_NEXT]) begin
                if (run == 0) first = i;
                run++;
                if (run == cnt) return 1'b1;
            end else begin
                run = 0;
            end
        end
        return 1'b0;
    endfunction

    function automatic cpra_pkg::t_result predict_cmd(input bit cmd,
                                                      input logic [cpra_pkg::CNT_W-1:0] cnt,
                                                      input logic [cpra_pkg::TYPE_W-1:0] ptype,
                                                      input logic [cpra_pkg::IDX_W-1:0] idx);
        int len;
        int old;
        int st;
        int n;
        int i;
        bit found;
        logic [cpra_pkg::FLAG_W-1:0] f;
        cpra_pkg::t_result r;
        len = managed_len();
        r.status = cpra_pkg::ST_OK;
        st = 0;
        n = 0;
        if (cmd == CMD_ALLOC) begin
            if (cnt == 0) begin
                r.status = cpra_pkg::ST_ZERO;
            end else begin
                old = search_hint;
                found = 1'b0;
                if (old < len) found = find_free_run(old, len, int'(cnt), st);
                if (!found && old != 0)
                    found = find_free_run(0, (old < len) ? old : len, int'(cnt), st);
                if (!found) begin
                    r.status = cpra_pkg::ST_NOSPACE;
                    st = 0;
                    search_hint = 0;
                end else begin
                    for (i = 0; i < cnt; i++) begin
                        f = {(i + 1 < cnt), (i == 0), 1'b1, ptype};
                        pg_flags[st + i] = f;
                    end
                    search_hint = st + int'(cnt);
                    if (search_hint >= len) search_hint = 0;
                    alloc_total += int'(cnt);
                    n = int'(cnt);
                end
            end
        end else begin
            st = int'(idx);
            if (idx >= len) begin
                r.status = cpra_pkg::ST_BOUNDS;
            end else if (!pg_flags[idx][cpra_pkg::FB_FIRST]) begin
                r.status = cpra_pkg::ST_NOTHEAD;
            end else begin
                for (i = int'(idx); i < len; i++) begin
                    f = pg_flags[i];
                    if (!f[cpra_pkg::FB_ALLOC]) break;
                    pg_flags[i] = '0;
                    n++;
                    if (!f[cpra_pkg::FB_NEXT]) break;
                end
                alloc_total -= (n <= alloc_total) ? n : alloc_total;
                search_hint = int'(idx);
            end
        end
        r.start = st[cpra_pkg::IDX_W-1:0];
        r.done  = n[cpra_pkg::CNT_W-1:0];
        r.total = alloc_total[cpra_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic t_row mk(input bit cmd, input int cnt, input int ptype, input int idx);
        t_row w;
        w.is_cfg = 1'b0;
        w.typed = 1'b0;
        w.cmd = cmd;
        w.cnt = cnt[cpra_pkg::CNT_W-1:0];
        w.ptype = ptype[cpra_pkg::TYPE_W-1:0];
        w.idx = idx[cpra_pkg::IDX_W-1:0];
        w.want = '0;
        return w;
    endfunction

    function automatic t_row mkt(input bit cmd, input int cnt, input int ptype, input int idx,
                                 input cpra_pkg::t_status st, input int start, input int done,
                                 input int total);
        t_row w;
        w = mk(cmd, cnt, ptype, idx);
        w.typed = 1'b1;
        w.want.status = st;
        w.want.start = start[cpra_pkg::IDX_W-1:0];
        w.want.done = done[cpra_pkg::CNT_W-1:0];
        w.want.total = total[cpra_pkg::CNT_W-1:0];
        return w;
    endfunction

    function automatic t_row mkc(input int v);
        t_row w;
        w = mk(CMD_ALLOC, 0, 0, 0);
        w.is_cfg = 1'b1;
        w.cnt = v[cpra_pkg::CNT_W-1:0];
        return w;
    endfunction

    // entered and left at a falling edge
    task automatic send_word(input bit cmd, input logic [cpra_pkg::CNT_W-1:0] cnt,
                             input logic [cpra_pkg::TYPE_W-1:0] ptype,
                             input logic [cpra_pkg::IDX_W-1:0] idx,
                             input bit typed, input cpra_pkg::t_result want);
        int g;
        cpra_pkg::t_result r;
        g = pick_gap();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        push <= 1'b1;
        i_cmd <= cmd;
        i_run_length <= cnt;
        i_page_type <= ptype;
        i_page_index <= idx;
        do @(posedge i_clk); while (full);
        r = predict_cmd(cmd, cnt, ptype, idx);
        if (cmd == CMD_ALLOC && r.status == cpra_pkg::ST_OK) head_q.push_back(int'(r.start));
        result_q.push_back(typed ? want : r);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        @(negedge i_clk);
        while (result_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_cfg(input int v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v[cpra_pkg::CNT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        pages_cfg = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic run_random(input int n);
        int len;
        int k;
        int cmax;
        int rnd;
        bit cmd;
        logic [cpra_pkg::CNT_W-1:0]  cnt;
        logic [cpra_pkg::IDX_W-1:0]  idx;
        logic [cpra_pkg::TYPE_W-1:0] ptype;
        for (int j = 0; j < n; j++) begin
            len = managed_len();
            rnd = $urandom;
            idx = rnd[cpra_pkg::IDX_W-1:0];
            if ($urandom_range(0, 9) < 7) begin
                if (head_q.size() > 0 && $urandom_range(0, 1)) begin
                    cmd = CMD_FREE;
                    k = $urandom_range(0, head_q.size() - 1);
                    rnd = head_q[k];
                    idx = rnd[cpra_pkg::IDX_W-1:0];
                    head_q.delete(k);
                    rnd = $urandom;
                    cnt = rnd[cpra_pkg::CNT_W-1:0];
                end else begin
                    cmd = CMD_ALLOC;
                    cmax = (len > 16) ? 16 : ((len == 0) ? 1 : len);
                    rnd = $urandom_range(1, cmax);
                    cnt = rnd[cpra_pkg::CNT_W-1:0];
                end
            end else begin
                rnd = $urandom;
                cmd = rnd[0];
                case ($urandom_range(0, 3))
                    0: cnt = '0;
                    1: begin
                        rnd = $urandom;
                        cnt = rnd[cpra_pkg::CNT_W-1:0];
                    end
                    2: cnt = 13'd4096;
                    default: cnt = len[cpra_pkg::CNT_W-1:0];
                endcase
            end
            rnd = $urandom;
            ptype = rnd[cpra_pkg::TYPE_W-1:0];
            send_word(cmd, cnt, ptype, idx, 1'b0, '0);
        end
    endtask

    // result side
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
                if ($urandom_range(0, 3) == 0) hold = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cpra_pkg::t_result e;
        if (i_rst_n && pop && !empty) begin
            if (result_q.size() == 0) begin
                $display("%0t unexpected word status %0d", $realtime, o_status);
                err_cnt++;
            end else begin
                e = result_q.pop_front();
                if (o_status !== e.status) begin
                    $display("%0t status exp %0d got %0d", $realtime, e.status, o_status);
                    err_cnt++;
                end
                if (o_start_index !== e.start) begin
                    $display("%0t start exp %0d got %0d", $realtime, e.start, o_start_index);
                    err_cnt++;
                end
                if (o_pages_done !== e.done) begin
                    $display("%0t done exp %0d got %0d", $realtime, e.done, o_pages_done);
                    err_cnt++;
                end
                if (o_allocated_total !== e.total) begin
                    $display("%0t total exp %0d got %0d", $realtime, e.total,
                             o_allocated_total);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < cpra_pkg::NUM_PAGES_DEF; i++) pg_flags[i] = '0;
        search_hint = 0;
        alloc_total = 0;
        pages_cfg = int'(cpra_pkg::PAGES_RST);
        dir_rows = '{
            mkt(CMD_ALLOC, 0, 12'h123, 0, cpra_pkg::ST_ZERO, 0, 0, 0),
            mkt(CMD_ALLOC, 1, 12'hfff, 12'hfff, cpra_pkg::ST_OK, 0, 1, 1),
            mkt(CMD_ALLOC, 4096, 0, 0, cpra_pkg::ST_NOSPACE, 0, 0, 1),
            mkt(CMD_ALLOC, 8191, 12'hfff, 0, cpra_pkg::ST_NOSPACE, 0, 0, 1),
            mkt(CMD_FREE, 0, 0, 4095, cpra_pkg::ST_NOTHEAD, 4095, 0, 1),
            mkt(CMD_FREE, 8191, 0, 0, cpra_pkg::ST_OK, 0, 1, 0),
            mkt(CMD_ALLOC, 4096, 0, 0, cpra_pkg::ST_OK, 0, 4096, 4096),
            mkt(CMD_FREE, 0, 0, 0, cpra_pkg::ST_OK, 0, 4096, 0),
            mkt(CMD_FREE, 0, 0, 1, cpra_pkg::ST_NOTHEAD, 1, 0, 0),
            mk(CMD_ALLOC, 3, 12'habc, 0),
            mk(CMD_ALLOC, 5, 12'h543, 0),
            mk(CMD_FREE, 0, 0, 3),
            mk(CMD_ALLOC, 2, 12'h00f, 0),
            mkc(16),
            mk(CMD_ALLOC, 10, 12'h0f0, 0),
            mk(CMD_ALLOC, 10, 12'h0f0, 0),
            mk(CMD_FREE, 0, 0, 20),
            mkc(0),
            mk(CMD_ALLOC, 1, 0, 0),
            mk(CMD_FREE, 0, 0, 0),
            mkc(8191),
            mk(CMD_FREE, 0, 0, 0),
            mk(CMD_ALLOC, 4095, 12'h5a5, 0),
            mk(CMD_ALLOC, 2, 12'ha5a, 0)
        };
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg)
                write_cfg(int'(dir_rows[i].cnt));
            else
                send_word(dir_rows[i].cmd, dir_rows[i].cnt, dir_rows[i].ptype,
                          dir_rows[i].idx, dir_rows[i].typed, dir_rows[i].want);
        end
        head_q.push_back(0);

        write_cfg(4096);
        run_random(15);
        write_cfg(1);
        run_random(15);
        write_cfg(32);
        run_random(15);
        wait_drained();
        run_random(15);
        write_cfg(200);
        no_idle = 1'b1;
        run_random(20);
        no_idle = 1'b0;
        write_cfg(8191);
        run_random(20);
        write_cfg(0);
        run_random(8);
        write_cfg(64);
        run_random(15);

        wait_drained();
        repeat (50) @(posedge i_clk);
        if (err_cnt == 0)
            $display("tb_contiguous_page_run_allocator passed");
        else
            $display("tb_contiguous_page_run_allocator failed");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/core/cpra_pkg.sv
rtl/core/cpra_fifo.sv
rtl/core/cpra_front.sv
rtl/core/cpra_engine.sv
rtl/core/contiguous_page_run_allocator.sv
rtl/core/cpra_checker.sv
verif/tb_contiguous_page_run_allocator.sv
